### src/etw_pkg.sv
package etw_pkg;

   // item and register widths
   localparam int VALUE_WIDTH = 16;
   localparam int TIME_WIDTH  = 16;
   localparam int CURVE_WIDTH = 2;
   localparam int INDEX_WIDTH = 2;

   // q8 progress and weight
   localparam int FRAC_BITS    = 8;
   localparam int EASE_WIDTH   = FRAC_BITS + 1;
   localparam int ELAPSED_WIDTH = TIME_WIDTH + 1;

   // shared multiplier operands and product
   localparam int DIFF_WIDTH = VALUE_WIDTH + 1;
   localparam int MUL_B_WIDTH = EASE_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + MUL_B_WIDTH;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_WIDTH = ((TIME_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS       = VALUE_WIDTH + 2;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [EASE_WIDTH-1:0] EASE_ONE = EASE_WIDTH'(1 << FRAC_BITS);

   // request kinds
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   // curve codes
   localparam logic [CURVE_WIDTH-1:0] CURVE_LINEAR   = 2'd0;
   localparam logic [CURVE_WIDTH-1:0] CURVE_EASE_IN  = 2'd1;
   localparam logic [CURVE_WIDTH-1:0] CURVE_EASE_OUT = 2'd2;
   localparam logic [CURVE_WIDTH-1:0] CURVE_IN_OUT   = 2'd3;

   // register indexes
   localparam logic [INDEX_WIDTH-1:0] REG_START    = 2'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_END      = 2'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_DURATION = 2'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_CURVE    = 2'd3;

   typedef logic [TIME_WIDTH-1:0]        time_type;
   typedef logic [FRAC_BITS-1:0]         progress_type;
   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic signed [MUL_B_WIDTH-1:0] mul_b_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   // divider handshake with the sequencer
   typedef struct packed {
      logic     start;
      time_type num;
      time_type den;
   } div_req_type;

   typedef struct packed {
      logic         done;
      progress_type quot;
   } div_rsp_type;

endpackage

### src/etw_div.sv
module etw_div
   import etw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // restoring divider, one quotient bit per cycle; num < den holds on start
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]  den_ff, den_in;
   progress_type           quot_ff, quot_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [TIME_WIDTH:0]    shifted;
   logic [TIME_WIDTH+1:0]  trial;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[TIME_WIDTH+1]) begin
            rem_in  = trial[TIME_WIDTH-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[TIME_WIDTH-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### src/etw_mul.sv
module etw_mul
   import etw_pkg::*;
(
   input  logic      clock,
   input  diff_type  mul_a,
   input  mul_b_type mul_b,
   output prod_type  product
);

   // shared signed multiplier, product registered
   prod_type product_ff, product_in;

   always_comb begin
      product_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### src/eased_tween_interpolator_core.sv
// timed value interpolator: restart (tuser 1) loads start_value and arms a run; tick (tuser 0)
// adds its delta time to elapsed time and produces the eased value between start_value and
// end_value, or end_value with finished set once elapsed time reaches the programmed duration.
// every request transaction yields exactly one response transaction with value, active and
// finished. for a restart, a tick while idle and a finishing tick, the sequencer goes from
// idle straight to the done state. an ongoing tick runs the 8-step serial divider for the q8
// progress and then one pass (linear) or two passes (eased curves) through the single shared
// multiplier on the way to the done state, which loads the output register.
// req_tready drops while an item is worked on and comes back on the edge that loads the
// response, and stays low while the result waits for a full output register. the response
// sits in an output register, so the next request is taken while it waits. configuration
// registers are written through csr_we/csr_index/csr_wdata and must change only when idle
module eased_tween_interpolator_core
   import etw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request: tdata = delta[15:0], tuser = req_type[0]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [0:0]                req_tuser,
   // response: tdata = value[15:0], active[16], finished[17], zero pad[23:18]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // configuration write port
   input  logic                      csr_we,
   input  logic [INDEX_WIDTH-1:0]    csr_index,
   input  logic [VALUE_WIDTH-1:0]    csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;  // serial divide for progress
   localparam logic [2:0] ST_SQR  = 3'd2;  // square product for the curve
   localparam logic [2:0] ST_SCL  = 3'd3;  // scale product for the value
   localparam logic [2:0] ST_DONE = 3'd4;  // hand the result to the output register

   // configuration registers
   logic signed [VALUE_WIDTH-1:0] start_ff, start_in;
   logic signed [VALUE_WIDTH-1:0] end_ff, end_in;
   time_type                      dur_ff, dur_in;
   logic [CURVE_WIDTH-1:0]        curve_ff, curve_in;

   // animation state
   logic [2:0]                    state_ff, state_in;
   logic [ELAPSED_WIDTH-1:0]      elapsed_ff, elapsed_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          running_ff, running_in;
   logic                          done_ff, done_in;
   progress_type                  prog_ff, prog_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;

   // shared units
   div_req_type                   div_req;
   div_rsp_type                   div_rsp;
   diff_type                      mul_a;
   mul_b_type                     mul_b;
   prod_type                      product;

   // datapath helpers
   logic                          accept;
   logic                          req_kind;
   time_type                      delta;
   logic [ELAPSED_WIDTH-1:0]      elapsed_sum;
   diff_type                      span;
   logic [EASE_WIDTH-1:0]         sq_opd;
   logic [EASE_WIDTH-1:0]         sq_shift;
   logic [EASE_WIDTH-1:0]         weight;
   logic                          rising;
   prod_type                      prod_adj;
   prod_type                      prod_scaled;
   diff_type                      value_sum;

   assign req_kind    = req_tuser[0];
   assign delta       = req_tdata[TIME_WIDTH-1:0];
   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign elapsed_sum = elapsed_ff + {1'b0, delta};
   assign span        = {end_ff[VALUE_WIDTH-1], end_ff} - {start_ff[VALUE_WIDTH-1], start_ff};

   always_comb begin
      // operand to square: p for ease-in and the lower half of in-out, 256-p otherwise
      if (curve_ff == CURVE_EASE_IN
          || (curve_ff == CURVE_IN_OUT && !div_rsp.quot[FRAC_BITS-1])) begin
         sq_opd = {1'b0, div_rsp.quot};
      end else begin
         sq_opd = EASE_ONE - {1'b0, div_rsp.quot};
      end

      // in-out squares half the distance, so divide by 128 instead of 256
      if (curve_ff == CURVE_IN_OUT) begin
         sq_shift = product[FRAC_BITS+EASE_WIDTH-2:FRAC_BITS-1];
      end else begin
         sq_shift = product[FRAC_BITS+EASE_WIDTH-1:FRAC_BITS];
      end
      rising = (curve_ff == CURVE_EASE_IN)
               || (curve_ff == CURVE_IN_OUT && !prog_ff[FRAC_BITS-1]);
      weight = rising ? sq_shift : (EASE_ONE - sq_shift);

      // signed divide by 256 that truncates toward zero
      prod_adj    = product + {{(PROD_WIDTH-FRAC_BITS){1'b0}},
                               {FRAC_BITS{product[PROD_WIDTH-1]}}};
      prod_scaled = prod_adj >>> FRAC_BITS;
      value_sum   = DIFF_WIDTH'(start_ff) + prod_scaled[DIFF_WIDTH-1:0];
   end

   always_comb begin
      start_in     = start_ff;
      end_in       = end_ff;
      dur_in       = dur_ff;
      curve_in     = curve_ff;
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      value_in     = value_ff;
      running_in   = running_ff;
      done_in      = done_ff;
      prog_in      = prog_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req.start = 1'b0;
      div_req.num   = elapsed_sum[TIME_WIDTH-1:0];
      div_req.den   = dur_ff;
      mul_a         = span;
      mul_b         = '0;

      if (csr_we) begin
         case (csr_index)
            REG_START:    start_in = csr_wdata;
            REG_END:      end_in = csr_wdata;
            REG_DURATION: dur_in = csr_wdata[TIME_WIDTH-1:0];
            REG_CURVE:    curve_in = csr_wdata[CURVE_WIDTH-1:0];
            default:      ;
         endcase
      end

      // response transaction completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               if (req_kind == REQ_RESTART) begin
                  elapsed_in = '0;
                  value_in   = start_ff;
                  running_in = 1'b1;
                  done_in    = 1'b0;
               end else if (running_ff) begin
                  elapsed_in = elapsed_sum;
                  // also covers a zero duration
                  if (elapsed_sum >= {1'b0, dur_ff}) begin
                     value_in   = end_ff;
                     running_in = 1'b0;
                     done_in    = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               prog_in = div_rsp.quot;
               if (curve_ff == CURVE_LINEAR) begin
                  mul_b    = {{(MUL_B_WIDTH-FRAC_BITS){1'b0}}, div_rsp.quot};
                  state_in = ST_SCL;
               end else begin
                  mul_a    = {{(DIFF_WIDTH-EASE_WIDTH){1'b0}}, sq_opd};
                  mul_b    = {1'b0, sq_opd};
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            mul_b    = {1'b0, weight};
            state_in = ST_SCL;
         end
         ST_SCL: begin
            value_in = value_sum[VALUE_WIDTH-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_WIDTH-RSP_BITS){1'b0}}, done_ff, running_ff, value_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         end_ff       <= '0;
         dur_ff       <= '0;
         curve_ff     <= CURVE_LINEAR;
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
         value_ff     <= '0;
         running_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         end_ff       <= end_in;
         dur_ff       <= dur_in;
         curve_ff     <= curve_in;
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         value_ff     <= value_in;
         running_ff   <= running_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prog_ff     <= prog_in;
      rsp_data_ff <= rsp_data_in;
   end

   // serial progress divider
   etw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // multiplier shared by curve square and value scaling
   etw_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### src/etw_checker.sv
module etw_checker
   import etw_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request at a time: ready drops after a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a run cannot be active and finished at once
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[VALUE_WIDTH] && rsp_tdata[VALUE_WIDTH+1]))
      else $error("active and finished both set");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind eased_tween_interpolator_core etw_checker u_etw_checker (.*);

### verif/eased_tween_interpolator_core_tb.sv
module eased_tween_interpolator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import etw_pkg::*;

   // quiet cycles before the run is declared hung
   localparam int STALL_LIMIT     = 2000;
   // cycles allowed after the last response before the registers move
   localparam int SETTLE_CYCLES   = 24;
   // long receiver hold-off that backs the core up
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASES_PER_MODE = 8;
   localparam int ITEMS_PER_PHASE = 50;

   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 16'sh8000;
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 16'sh7fff;

   // response fields, laid out as in rsp_tdata
   typedef struct packed {
      logic                          finished;
      logic                          active;
      logic signed [VALUE_WIDTH-1:0] value;
   } tween_out_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type           rk;
      logic [INDEX_WIDTH-1:0] idx;
      logic                   kind;
      logic [15:0]            data;
      logic                   typed;
      tween_out_type          want;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [0:0]                req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [INDEX_WIDTH-1:0]    csr_index = '0;
   logic [VALUE_WIDTH-1:0]    csr_wdata = '0;

   // shadow copy of the registers
   logic signed [VALUE_WIDTH-1:0] sh_start = '0;
   logic signed [VALUE_WIDTH-1:0] sh_end = '0;
   time_type                      sh_duration = '0;
   logic [CURVE_WIDTH-1:0]        sh_curve = '0;

   // animation state as the core should hold it
   logic [ELAPSED_WIDTH-1:0]      tween_elapsed = '0;
   logic signed [VALUE_WIDTH-1:0] tween_value = '0;
   logic                          tween_running = 1'b0;
   logic                          tween_done = 1'b0;

   tween_out_type pending_tween_q[$];
   stim_row_type  dir_table[$];

   int error_cnt    = 0;
   int quiet_cycles = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_req     = 0;
   int hold_ack     = 0;
   int hold_left    = 0;

   eased_tween_interpolator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // advance the shadow animation by one request and return the response it should give
   function automatic tween_out_type advance_tween(input logic kind, input time_type delta);
      longint        el;
      longint        span;
      longint        prog;
      longint        wt;
      longint        q;
      longint        s;
      longint        diff;
      tween_out_type r;
      if (kind == REQ_RESTART) begin
         tween_elapsed = '0;
         tween_value   = sh_start;
         tween_running = 1'b1;
         tween_done    = 1'b0;
      end else if (tween_running) begin
         el = longint'(tween_elapsed) + longint'(delta);
         // elapsed time saturates instead of wrapping
         if (el > (longint'(1) << ELAPSED_WIDTH) - 1)
            el = (longint'(1) << ELAPSED_WIDTH) - 1;
         tween_elapsed = el[ELAPSED_WIDTH-1:0];
         span = longint'(sh_duration);
         if (el >= span || span == 0) begin
            // run complete: land exactly on the end value
            tween_value   = sh_end;
            tween_running = 1'b0;
            tween_done    = 1'b1;
         end else begin
            // q8 progress, always 0..255 here
            prog = (el * 256) / span;
            case (sh_curve)
               CURVE_EASE_IN: begin
                  wt = (prog * prog) / 256;
               end
               CURVE_EASE_OUT: begin
                  q  = 256 - prog;
                  wt = 256 - (q * q) / 256;
               end
               CURVE_IN_OUT: begin
                  if (prog < 128) begin
                     q  = prog * 2;
                     wt = (q * q) / 512;
                  end else begin
                     q  = (256 - prog) * 2;
                     wt = 256 - (q * q) / 512;
                  end
               end
               default: begin
                  wt = prog;
               end
            endcase
            s    = longint'(sh_start);
            diff = longint'(sh_end) - s;
            // signed division truncates toward zero
            tween_value = VALUE_WIDTH'(s + (diff * wt) / 256);
         end
      end
      r.value    = tween_value;
      r.active   = tween_running;
      r.finished = tween_done;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(input logic [INDEX_WIDTH-1:0] idx,
                                            input logic [15:0] data);
      stim_row_type r;
      r       = '0;
      r.rk    = ROW_CFG;
      r.idx   = idx;
      r.data  = data;
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic kind, input logic [15:0] delta);
      stim_row_type r;
      r      = '0;
      r.rk   = ROW_ITEM;
      r.kind = kind;
      r.data = delta;
      return r;
   endfunction

   // item row whose response is written down by hand
   function automatic stim_row_type item_chk(input logic kind, input logic [15:0] delta,
                                             input logic signed [VALUE_WIDTH-1:0] v,
                                             input logic a, input logic f);
      stim_row_type r;
      r               = item_row(kind, delta);
      r.typed         = 1'b1;
      r.want.value    = v;
      r.want.active   = a;
      r.want.finished = f;
      return r;
   endfunction

   // mostly random, now and then a range extreme
   function automatic logic [VALUE_WIDTH-1:0] rand_value();
      case ($urandom_range(7))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         default: return VALUE_WIDTH'($urandom_range(65535));
      endcase
   endfunction

   // one register write; the core must be idle
   task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_START:    sh_start    = data;
         REG_END:      sh_end      = data;
         REG_DURATION: sh_duration = data;
         REG_CURVE:    sh_curve    = data[CURVE_WIDTH-1:0];
         default:      ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // offer one request transaction and log the response it should produce
   task automatic issue_request(input logic kind, input time_type delta,
                                input logic typed, input tween_out_type want);
      tween_out_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_WIDTH'(delta);
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = advance_tween(kind, delta);
      pending_tween_q.push_back(typed ? want : pred);
   endtask

   // stop offering, wait for every response, then let the pipeline go quiet
   task automatic settle_tween();
      req_tvalid <= 1'b0;
      while (pending_tween_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: compare each response transaction, then pick next cycle's tready
   always @(posedge clock) begin
      tween_out_type got;
      tween_out_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (pending_tween_q.size() == 0) begin
            $display("%0t ns: response with nothing expected, actual value %0d",
                     $time, got.value, " active %0b finished %0b",
                     got.active, got.finished);
            error_cnt++;
         end else begin
            want = pending_tween_q.pop_front();
            if (got.value !== want.value) begin
               $display("%0t ns: value expected %0d actual %0d", $time, want.value, got.value);
               error_cnt++;
            end
            if (got.active !== want.active) begin
               $display("%0t ns: active expected %0b actual %0b", $time, want.active,
                        got.active);
               error_cnt++;
            end
            if (got.finished !== want.finished) begin
               $display("%0t ns: finished expected %0b actual %0b", $time, want.finished,
                        got.finished);
               error_cnt++;
            end
         end
      end
      // a new hold-off request starts a long stretch with tready low
      if (hold_ack != hold_req) begin
         hold_ack  = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog: ends a run in which no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("eased_tween_interpolator_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic     kind;
      time_type delta;
      int       roll;

      // directed table: corner values, every curve, the special cases
      // idle tick straight after reset holds the reset state
      dir_table.push_back(item_chk(REQ_TICK, 16'h1234, 16'sd0, 1'b0, 1'b0));
      // restart with all registers at zero
      dir_table.push_back(item_chk(REQ_RESTART, 16'hffff, 16'sd0, 1'b1, 1'b0));
      // zero duration: first tick finishes
      dir_table.push_back(item_chk(REQ_TICK, 16'h0000, 16'sd0, 1'b0, 1'b1));
      // tick after finishing changes nothing
      dir_table.push_back(item_chk(REQ_TICK, 16'hffff, 16'sd0, 1'b0, 1'b1));
      dir_table.push_back(cfg_row(REG_START, VAL_MIN));
      dir_table.push_back(cfg_row(REG_END, VAL_MAX));
      dir_table.push_back(cfg_row(REG_DURATION, 16'hffff));
      dir_table.push_back(cfg_row(REG_CURVE, 16'(CURVE_LINEAR)));
      dir_table.push_back(item_chk(REQ_RESTART, 16'h0000, VAL_MIN, 1'b1, 1'b0));
      dir_table.push_back(item_row(REQ_TICK, 16'h0000));
      dir_table.push_back(item_row(REQ_TICK, 16'h0001));
      dir_table.push_back(item_row(REQ_TICK, 16'h7fff));
      dir_table.push_back(item_chk(REQ_TICK, 16'hffff, VAL_MAX, 1'b0, 1'b1));
      // curve changed between ticks of one run
      dir_table.push_back(cfg_row(REG_CURVE, 16'(CURVE_EASE_IN)));
      dir_table.push_back(item_chk(REQ_RESTART, 16'h5555, VAL_MIN, 1'b1, 1'b0));
      dir_table.push_back(item_row(REQ_TICK, 16'h4000));
      dir_table.push_back(cfg_row(REG_CURVE, 16'(CURVE_EASE_OUT)));
      dir_table.push_back(item_row(REQ_TICK, 16'h4000));
      // ease-in-out on both sides of the half-way point
      dir_table.push_back(cfg_row(REG_CURVE, 16'(CURVE_IN_OUT)));
      dir_table.push_back(item_chk(REQ_RESTART, 16'haaaa, VAL_MIN, 1'b1, 1'b0));
      dir_table.push_back(item_row(REQ_TICK, 16'd8000));
      dir_table.push_back(item_row(REQ_TICK, 16'd40000));
      // duration cut below elapsed time: next tick finishes
      dir_table.push_back(cfg_row(REG_DURATION, 16'd1000));
      dir_table.push_back(item_chk(REQ_TICK, 16'h0000, VAL_MAX, 1'b0, 1'b1));
      // descending run, then the largest tick
      dir_table.push_back(cfg_row(REG_START, VAL_MAX));
      dir_table.push_back(cfg_row(REG_END, VAL_MIN));
      dir_table.push_back(item_chk(REQ_RESTART, 16'h0000, VAL_MAX, 1'b1, 1'b0));
      dir_table.push_back(item_row(REQ_TICK, 16'd500));
      dir_table.push_back(item_chk(REQ_TICK, 16'hffff, VAL_MIN, 1'b0, 1'b1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      req_idle_pct = 6;
      rsp_idle_pct = 88;
      foreach (dir_table[i]) begin
         if (dir_table[i].rk == ROW_CFG) begin
            settle_tween();
            write_reg(dir_table[i].idx, dir_table[i].data);
         end else begin
            issue_request(dir_table[i].kind, dir_table[i].data, dir_table[i].typed,
                          dir_table[i].want);
         end
      end

      // random part: three idling modes, several register settings in each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 6;
               rsp_idle_pct = 88;
            end
            1: begin
               req_idle_pct = 88;
               rsp_idle_pct = 6;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
            settle_tween();
            write_reg(REG_START, rand_value());
            write_reg(REG_END, rand_value());
            case ($urandom_range(9))
               0:       write_reg(REG_DURATION, 16'd0);
               1:       write_reg(REG_DURATION, 16'd1);
               2:       write_reg(REG_DURATION, 16'hffff);
               3, 4:    write_reg(REG_DURATION, 16'($urandom_range(2, 64)));
               default: write_reg(REG_DURATION, 16'($urandom_range(65, 65535)));
            endcase
            write_reg(REG_CURVE, 16'($urandom_range(3)));
            // back-pressure: receiver stalls for a long stretch while requests keep coming
            if (mode == 2 && ph == 0)
               hold_req++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               // mostly whole runs: restart, then ticks until finished
               if (!tween_running)
                  kind = ($urandom_range(99) < 85) ? REQ_RESTART : REQ_TICK;
               else
                  kind = ($urandom_range(99) < 5) ? REQ_RESTART : REQ_TICK;
               roll = $urandom_range(99);
               if (roll < 10)
                  delta = time_type'($urandom_range(65535));
               else if (roll < 15)
                  delta = '0;
               else
                  delta = time_type'($urandom_range(int'(sh_duration) / 4 + 1));
               issue_request(kind, delta, 1'b0, '0);
            end
         end
      end

      settle_tween();
      if (error_cnt == 0 && pending_tween_q.size() == 0) begin
         $display("eased_tween_interpolator_core_tb: done, clean");
      end else begin
         $display("eased_tween_interpolator_core_tb: done, errors");
      end
      $finish;
   end

endmodule
